// ----- sv/egld_pkg.sv -----
// ----------------------------------------------------------------------------
// Elevator group dispatch package
// Shared codes and control/status structures for the dispatch controller.
// ----------------------------------------------------------------------------
package egld_pkg;

  localparam logic [1:0] ACT_HALL = 2'd0;
  localparam logic [1:0] ACT_CAR  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [1:0] KIND_HALL = 2'd0;
  localparam logic [1:0] KIND_CAR  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] HEAD_UP   = 2'd0;
  localparam logic [1:0] HEAD_DOWN = 2'd1;
  localparam logic [1:0] HEAD_IDLE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOCAR  = 2'd1;
  localparam logic [1:0] ST_BADID  = 2'd2;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_ACTIVE  = 2'd1;
  localparam logic [1:0] REG_PENALTY = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;      // capture the input word
    logic       clr_best;  // restart the car search
    logic       eval;      // compare the car under the index
    logic       add_stop;  // apply a stop to the selected car
    logic       move;      // move the car under the index
    logic [2:0] idx;       // car index
    logic       use_best;  // result uses the search winner
  } egld_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] action;
    logic       found;
  } egld_sts_t;

endpackage

// ----- sv/egld_datapath.sv -----
// ----------------------------------------------------------------------------
// Elevator group dispatch datapath
// Car state, cost comparison, stop maps and result formation.
// ----------------------------------------------------------------------------
module egld_datapath #(
  parameter int NUM_CARS   = 8,
  parameter int NUM_FLOORS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  egld_pkg::egld_cmd_t  cmd,
  output egld_pkg::egld_sts_t  sts,
  input  logic [1:0]           in_action,
  input  logic [5:0]           in_floor,
  input  logic                 in_dir,
  input  logic [3:0]           in_car,
  input  logic                 dispatch_mode,
  input  logic [11:0]          reversal_penalty,
  output logic [2:0]           res_car_id,
  output logic [5:0]           res_floor,
  output logic [1:0]           res_heading,
  output logic                 res_door
);

  localparam logic [5:0] TOP = 6'(NUM_FLOORS - 1);

  logic [5:0]  pos_r  [NUM_CARS];
  logic [1:0]  dir_r  [NUM_CARS];
  logic [63:0] up_r   [NUM_CARS];
  logic [63:0] dn_r   [NUM_CARS];

  logic [1:0]  act_r;
  logic [5:0]  flr_r;
  logic [1:0]  want_r;
  logic [2:0]  tgt_r;
  logic        found_r;
  logic [2:0]  best_r;
  logic [12:0] cost_r;
  logic        door_r;

  logic [2:0]  sel;
  logic [5:0]  p;
  logic [5:0]  gap;
  logic [12:0] cost;
  logic        qual;
  logic        ahead;
  logic [63:0] up_n, dn_n;
  logic [5:0]  p_n;
  logic [1:0]  d_n;
  logic        door_n;
  logic [63:0] mask;

  // Heading rule after the stop maps change
  function automatic logic [1:0] heading(input logic [1:0] d, input logic [63:0] u,
                                          input logic [63:0] w);
    logic [1:0] h;
    h = egld_pkg::HEAD_IDLE;
    if (d == egld_pkg::HEAD_UP) begin
      h = (u != 0) ? egld_pkg::HEAD_UP : ((w != 0) ? egld_pkg::HEAD_DOWN : egld_pkg::HEAD_IDLE);
    end else if (d == egld_pkg::HEAD_DOWN) begin
      h = (w != 0) ? egld_pkg::HEAD_DOWN : ((u != 0) ? egld_pkg::HEAD_UP : egld_pkg::HEAD_IDLE);
    end else begin
      h = (u != 0) ? egld_pkg::HEAD_UP : ((w != 0) ? egld_pkg::HEAD_DOWN : egld_pkg::HEAD_IDLE);
    end
    return h;
  endfunction

  assign sel = cmd.use_best ? (act_r == egld_pkg::ACT_HALL ? best_r : tgt_r) : cmd.idx;

  // Cost of the car under the index
  always_comb begin
    p     = pos_r[cmd.idx];
    gap   = (p > flr_r) ? p - flr_r : flr_r - p;
    ahead = (want_r == egld_pkg::HEAD_UP) ? (flr_r >= p) : (flr_r <= p);
    qual  = 1'b1;
    if (dispatch_mode == 1'b0) begin
      if (dir_r[cmd.idx] == egld_pkg::HEAD_IDLE || (dir_r[cmd.idx] == want_r && ahead)) begin
        cost = {7'd0, gap};
      end else begin
        cost = {1'b0, reversal_penalty} + {7'd0, gap};
      end
    end else begin
      cost = {7'd0, gap};
      qual = (dir_r[cmd.idx] == want_r) || (dir_r[cmd.idx] == egld_pkg::HEAD_IDLE);
    end
  end

  // Stop addition or one-floor move for the selected car
  always_comb begin
    p_n    = pos_r[sel];
    up_n   = up_r[sel];
    dn_n   = dn_r[sel];
    d_n    = dir_r[sel];
    door_n = 1'b0;
    mask   = 64'd0;
    if (cmd.add_stop) begin
      if (flr_r == p_n) begin
        door_n = 1'b1;
      end else begin
        if (flr_r > p_n) up_n = up_n | (64'd1 << flr_r);
        else             dn_n = dn_n | (64'd1 << flr_r);
        d_n = heading(d_n, up_n, dn_n);
      end
    end else begin
      if (d_n == egld_pkg::HEAD_UP && up_n != 0) begin
        if (p_n < TOP) p_n = p_n + 6'd1;
        door_n = up_n[p_n];
      end else if (d_n == egld_pkg::HEAD_DOWN && dn_n != 0) begin
        if (p_n > 6'd0) p_n = p_n - 6'd1;
        door_n = dn_n[p_n];
      end
      if (door_n) begin
        mask = 64'd1 << p_n;
        up_n = up_n & ~mask;
        dn_n = dn_n & ~mask;
      end
      d_n = heading(d_n, up_n, dn_n);
    end
  end

  // Car state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CARS; i++) begin
        pos_r[i] <= 6'd0;
        dir_r[i] <= egld_pkg::HEAD_IDLE;
        up_r[i]  <= 64'd0;
        dn_r[i]  <= 64'd0;
      end
    end else if (cmd.add_stop || cmd.move) begin
      pos_r[sel] <= p_n;
      dir_r[sel] <= d_n;
      up_r[sel]  <= up_n;
      dn_r[sel]  <= dn_n;
    end
  end

  // Request capture, search and door flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      if (cmd.clr_best) found_r <= 1'b0;
      else if (cmd.eval && qual && (!found_r || cost < cost_r)) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      flr_r  <= (in_floor > TOP) ? TOP : in_floor;
      want_r <= in_dir ? egld_pkg::HEAD_DOWN : egld_pkg::HEAD_UP;
      tgt_r  <= in_car[2:0];
    end
    if (cmd.eval && qual && (!found_r || cost < cost_r)) begin
      best_r <= cmd.idx;
      cost_r <= cost;
    end
    if (cmd.add_stop || cmd.move) door_r <= door_n;
  end

  assign sts.action  = act_r;
  assign sts.found   = found_r;
  assign res_car_id  = sel;
  assign res_floor   = pos_r[sel];
  assign res_heading = dir_r[sel];
  assign res_door    = door_r;

endmodule

// ----- sv/egld_ctrl.sv -----
// ----------------------------------------------------------------------------
// Elevator group dispatch controller
// Sequences search, stop update, car moves and output words.
// ----------------------------------------------------------------------------
module egld_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_action,
  input  logic [3:0]          in_car,
  input  logic [3:0]          n_cars,
  input  egld_pkg::egld_sts_t sts,
  output egld_pkg::egld_cmd_t cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [1:0]          res_kind,
  output logic [1:0]          res_status,
  output logic                res_zero,
  output logic                res_last
);

  typedef enum logic [2:0] {S_IDLE, S_SRCH, S_ADD, S_MOVE, S_OUT} state_t;

  state_t     state_r;
  logic [2:0] idx_r;
  logic [1:0] kind_r;
  logic [1:0] stat_r;
  logic       zero_r;
  logic       last_r;
  logic [3:0] idx_ext;

  assign idx_ext   = {1'b0, idx_r};
  assign in_tready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res_kind  = kind_r;
  assign res_status = stat_r;
  assign res_zero  = zero_r;
  assign res_last  = last_r;

  // Command decode; a hall call whose search found no car leaves every car alone
  always_comb begin
    cmd          = '0;
    cmd.idx      = idx_r;
    cmd.load     = (state_r == S_IDLE) && in_tvalid;
    cmd.clr_best = cmd.load;
    cmd.eval     = (state_r == S_SRCH);
    cmd.add_stop = (state_r == S_ADD) && (kind_r != egld_pkg::KIND_HALL || sts.found);
    cmd.move     = (state_r == S_MOVE);
    cmd.use_best = (state_r == S_ADD) || (state_r == S_OUT && kind_r != egld_pkg::KIND_TICK);
  end

  // State and result tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 3'd0;
      kind_r  <= egld_pkg::KIND_HALL;
      stat_r  <= egld_pkg::ST_OK;
      zero_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          idx_r  <= 3'd0;
          stat_r <= egld_pkg::ST_OK;
          zero_r <= 1'b0;
          last_r <= 1'b1;
          if (in_tvalid) begin
            case (in_action)
              egld_pkg::ACT_HALL: begin
                kind_r <= egld_pkg::KIND_HALL;
                if (n_cars == 4'd0) begin
                  stat_r <= egld_pkg::ST_NOCAR;
                  zero_r <= 1'b1;
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_SRCH;
                end
              end
              egld_pkg::ACT_CAR: begin
                kind_r <= egld_pkg::KIND_CAR;
                if (in_car >= n_cars) begin
                  stat_r <= egld_pkg::ST_BADID;
                  zero_r <= 1'b1;
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_ADD;
                end
              end
              egld_pkg::ACT_TICK: begin
                kind_r <= egld_pkg::KIND_TICK;
                if (n_cars != 4'd0) state_r <= S_MOVE;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SRCH: begin
          if (idx_ext + 4'd1 >= n_cars) begin
            state_r <= S_ADD;
          end else begin
            idx_r <= idx_r + 3'd1;
          end
        end
        S_ADD: begin
          if (!sts.found && kind_r == egld_pkg::KIND_HALL) begin
            stat_r <= egld_pkg::ST_NOCAR;
            zero_r <= 1'b1;
          end
          state_r <= S_OUT;
        end
        S_MOVE: begin
          last_r  <= (idx_ext + 4'd1 >= n_cars);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            if (kind_r == egld_pkg::KIND_TICK && !last_r) begin
              idx_r   <= idx_r + 3'd1;
              state_r <= S_MOVE;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/elevator_group_look_dispatch.sv -----
// ----------------------------------------------------------------------------
// Elevator group LOOK dispatch
// Assigns hall and car calls to cars and steps cars on each tick.
// ----------------------------------------------------------------------------
// Hall call: a search over each car in service, the stop update, then the
// output word; a car call skips the search. Tick: one move and one output
// word per car in service. One item in work at a time; a new item is taken
// only once the last output word has been accepted.
// Reset (rst_n, synchronous): all cars at floor 0, idle, no stops;
// registers to LOOK mode, five cars, penalty 1000.
module elevator_group_look_dispatch #(
  parameter int NUM_CARS   = 8,
  parameter int NUM_FLOORS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,  // action[1:0]
  input  logic [15:0] in_tdata,  // floor[5:0], hall_direction[6], car[10:7]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser, // kind[1:0]
  output logic [15:0] out_tdata, // car_id[2:0], car_floor_out[8:3], car_heading[10:9],
                                 // door_opened[11], status[13:12]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        mode_r;
  logic [3:0]  active_r;
  logic [11:0] pen_r;
  logic [3:0]  n_cars;
  logic        wr;

  egld_pkg::egld_cmd_t cmd;
  egld_pkg::egld_sts_t sts;
  logic [2:0] r_id;
  logic [5:0] r_floor;
  logic [1:0] r_head;
  logic       r_door;
  logic [1:0] r_kind;
  logic [1:0] r_stat;
  logic       r_zero;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      active_r <= 4'd5;
      pen_r    <= 12'd1000;
    end else if (wr) begin
      case (cfg_paddr[3:2])
        egld_pkg::REG_MODE:    mode_r   <= cfg_pwdata[0];
        egld_pkg::REG_ACTIVE:  active_r <= cfg_pwdata[3:0];
        egld_pkg::REG_PENALTY: pen_r    <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      egld_pkg::REG_MODE:    cfg_prdata = {31'd0, mode_r};
      egld_pkg::REG_ACTIVE:  cfg_prdata = {28'd0, active_r};
      egld_pkg::REG_PENALTY: cfg_prdata = {20'd0, pen_r};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  assign n_cars = (active_r < 4'(NUM_CARS)) ? active_r : 4'(NUM_CARS);

  egld_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_action (in_tuser),
    .in_car    (in_tdata[10:7]),
    .n_cars, .sts, .cmd,
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_kind  (r_kind),
    .res_status(r_stat),
    .res_zero  (r_zero),
    .res_last  (out_tlast)
  );

  egld_datapath #(.NUM_CARS(NUM_CARS), .NUM_FLOORS(NUM_FLOORS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_action (in_tuser),
    .in_floor  (in_tdata[5:0]),
    .in_dir    (in_tdata[6]),
    .in_car    (in_tdata[10:7]),
    .dispatch_mode (mode_r),
    .reversal_penalty (pen_r),
    .res_car_id (r_id),
    .res_floor  (r_floor),
    .res_heading(r_head),
    .res_door   (r_door)
  );

  // Output word; failed requests report a zeroed car
  assign out_tuser = r_kind;
  assign out_tdata = r_zero ? {2'd0, r_stat, 12'd0}
                            : {2'd0, r_stat, r_door, r_head, r_floor, r_id};

endmodule

// ----- sv/egld_checker.sv -----
// ----------------------------------------------------------------------------
// Elevator group dispatch port checker
// Watches the ports of the top level for handshake and result rules.
// ----------------------------------------------------------------------------
module egld_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [1:0]  out_tuser,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // No new item is taken while a word waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted while output pending");

  // A failed request reports no door opening and is the last word
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13:12] != egld_pkg::ST_OK |-> !out_tdata[11] && out_tlast)
    else $error("failed request reports a car");

  // A hall or car call gives one word only
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != egld_pkg::KIND_TICK |-> out_tlast)
    else $error("call result not last");

endmodule

bind elevator_group_look_dispatch egld_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tuser, .out_tdata,
  .out_tlast
);
